// ===== hdl/hcio_pkg.sv =====
// Shared types and constants for the home computer I/O port block.
package hcio_pkg;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_SYNC  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam int KEY_ROWS_DEF    = 8;
  localparam int KEY_COLUMNS_DEF = 6;

  localparam int ADDR_W   = 16;
  localparam int KEY_W    = 48;
  localparam int RATE_W   = 26;
  localparam int WORD_W   = 32;
  localparam int FREQ_W   = 25;
  localparam int NUM_W    = (RATE_W - 1) + WORD_W;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int ROW_SEL_LSB = 8;

  localparam logic [7:0] PORT_VSYNC   = 8'hFD;
  localparam logic [7:0] PORT_KEYS    = 8'hFF;
  localparam logic [7:0] PORT_SPEAKER = 8'hFC;
  localparam logic [7:0] RD_IDLE      = 8'hFF;

  // timer / 10 == (timer * ceil(2^35 / 10)) >> 35 for every 32-bit timer
  localparam logic [WORD_W-1:0] TIMER_RECIP = 32'hCCCC_CCCD;
  localparam int TIMER_SHIFT = 35;

  localparam logic [FREQ_W-1:0] FREQ_MAX   = 25'h1FF_FFFF;
  localparam logic [RATE_W-1:0] RATE_RESET = 26'd3579545;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  measure_ok;
    logic  out_free;
  } ctrl_sts_t;

endpackage

// ===== hdl/hcio_if.sv =====
// Request and result channel interfaces.
interface hcio_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [hcio_pkg::ADDR_W-1:0]      port_address;
  logic [7:0]                       write_data;
  logic [hcio_pkg::WORD_W-1:0]      cycle_count;
  logic [hcio_pkg::WORD_W-1:0]      timer_ms;
  logic                             vsync_active;
  logic [hcio_pkg::KEY_W-1:0]       key_matrix;

  modport source (output valid, mode, port_address, write_data, cycle_count, timer_ms,
                  vsync_active, key_matrix, input ready);
  modport sink (input valid, mode, port_address, write_data, cycle_count, timer_ms,
                vsync_active, key_matrix, output ready);
endinterface

interface hcio_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  read_data;
  logic [hcio_pkg::FREQ_W-1:0] tone_frequency;
  logic                        tone_valid;

  modport source (output valid, read_data, tone_frequency, tone_valid, input ready);
  modport sink (input valid, read_data, tone_frequency, tone_valid, output ready);
endinterface

// ===== hdl/hcio_datapath.sv =====
// Datapath: request capture, port logic, speaker measurement, divider, result register.
module hcio_datapath #(
  parameter int KEY_ROWS    = hcio_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLUMNS = hcio_pkg::KEY_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_mode,
  input  logic [hcio_pkg::ADDR_W-1:0]     in_port_address,
  input  logic [7:0]                      in_write_data,
  input  logic [hcio_pkg::WORD_W-1:0]     in_cycle_count,
  input  logic [hcio_pkg::WORD_W-1:0]     in_timer_ms,
  input  logic                            in_vsync_active,
  input  logic [hcio_pkg::KEY_W-1:0]      in_key_matrix,
  input  logic                            cfg_wr_en,
  input  logic [hcio_pkg::RATE_W-1:0]     cfg_wr_data,
  input  hcio_pkg::ctrl_cmd_t             cmd,
  output hcio_pkg::ctrl_sts_t             sts,
  hcio_out_if.source                      out_ch
);

  localparam int WW = hcio_pkg::WORD_W;

  // captured request
  hcio_pkg::mode_t                  mode_r;
  logic [hcio_pkg::ADDR_W-1:0]      addr_r;
  logic                             wbit_r;
  logic [WW-1:0]                    now_r;
  logic [WW-1:0]                    timer_r;
  logic                             vsync_r;
  logic [hcio_pkg::KEY_W-1:0]       keys_r;

  // architectural state
  logic [hcio_pkg::RATE_W-1:0]      rate_r;
  logic                             spk_r;
  logic [WW-1:0]                    last_r;
  logic [WW-1:0]                    count_r;
  logic [WW-1:0]                    sum_r;

  // work registers
  logic [hcio_pkg::PROD_W-1:0]      work_r;
  logic [WW-1:0]                    rem_r;
  logic                             meas_r;

  // result register
  logic                             out_valid_r;
  logic [7:0]                       rd_r;
  logic [hcio_pkg::FREQ_W-1:0]      freq_r;
  logic                             tv_r;

  logic                             measure_ok;
  logic                             toggle;
  logic [WW-1:0]                    diff;
  logic [WW:0]                      rem_sh;
  logic                             qbit;
  logic [7:0]                       key_acc;
  logic [63:0]                      keys_ext;
  logic [WW-1:0]                    tq;
  logic [7:0]                       rd_nxt;
  logic [hcio_pkg::FREQ_W-1:0]      freq_nxt;
  logic [hcio_pkg::NUM_W-1:0]       quo;
  logic [hcio_pkg::NUM_W-1:0]       num_prod;
  logic [hcio_pkg::PROD_W-1:0]      tim_prod;

  assign measure_ok = (last_r != '0) && (count_r != '0) && (sum_r != '0);
  assign toggle     = (addr_r[7:0] == hcio_pkg::PORT_SPEAKER) && (wbit_r != spk_r);
  assign diff       = (now_r >= last_r) ? (now_r - last_r) : (last_r - now_r);

  assign num_prod = hcio_pkg::NUM_W'(rate_r[hcio_pkg::RATE_W-1:1]) *
                    hcio_pkg::NUM_W'(count_r);
  assign tim_prod = hcio_pkg::PROD_W'(timer_r) * hcio_pkg::PROD_W'(hcio_pkg::TIMER_RECIP);

  assign rem_sh = {rem_r, work_r[hcio_pkg::NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, sum_r});

  assign quo = work_r[hcio_pkg::NUM_W-1:0];

  always_comb begin
    keys_ext = 64'(keys_r);
    key_acc  = '0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      if (!addr_r[hcio_pkg::ROW_SEL_LSB + r]) begin
        key_acc = key_acc | 8'(keys_ext[r*KEY_COLUMNS +: KEY_COLUMNS]);
      end
    end
  end

  assign tq = WW'(work_r >> hcio_pkg::TIMER_SHIFT);

  always_comb begin
    rd_nxt   = hcio_pkg::RD_IDLE;
    freq_nxt = '0;
    unique case (mode_r)
      hcio_pkg::MODE_READ: begin
        priority if (addr_r[7:2] == 6'd0) begin
          rd_nxt = 8'(tq >> {addr_r[1:0], 3'b000});
        end else if (addr_r[7:0] == hcio_pkg::PORT_VSYNC) begin
          rd_nxt = {7'd0, vsync_r};
        end else if (addr_r[7:0] == hcio_pkg::PORT_KEYS) begin
          rd_nxt = ~key_acc;
        end else begin
          rd_nxt = hcio_pkg::RD_IDLE;
        end
      end
      hcio_pkg::MODE_SYNC: begin
        if (meas_r) begin
          freq_nxt = (|quo[hcio_pkg::NUM_W-1:hcio_pkg::FREQ_W]) ? hcio_pkg::FREQ_MAX
                                                               : quo[hcio_pkg::FREQ_W-1:0];
        end
      end
      hcio_pkg::MODE_WRITE, hcio_pkg::MODE_NONE: begin
        rd_nxt = hcio_pkg::RD_IDLE;
      end
      default: rd_nxt = hcio_pkg::RD_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= hcio_pkg::mode_t'(in_mode);
      addr_r  <= in_port_address;
      wbit_r  <= in_write_data[0];
      now_r   <= in_cycle_count;
      timer_r <= in_timer_ms;
      vsync_r <= in_vsync_active;
      keys_r  <= in_key_matrix;
    end
    if (cmd.exec) begin
      meas_r <= measure_ok;
      rem_r  <= '0;
      if (mode_r == hcio_pkg::MODE_SYNC) begin
        work_r <= hcio_pkg::PROD_W'(num_prod);
      end else begin
        work_r <= tim_prod;
      end
    end else if (cmd.div_step) begin
      rem_r  <= qbit ? WW'(rem_sh - {1'b0, sum_r}) : rem_sh[WW-1:0];
      work_r <= {work_r[hcio_pkg::PROD_W-2:0], qbit};
    end
    if (cmd.out_load) begin
      rd_r   <= rd_nxt;
      freq_r <= freq_nxt;
      tv_r   <= (mode_r == hcio_pkg::MODE_SYNC);
    end
  end

  // architectural state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= hcio_pkg::RATE_RESET;
      spk_r       <= 1'b0;
      last_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        if (mode_r == hcio_pkg::MODE_WRITE && toggle) begin
          spk_r  <= wbit_r;
          last_r <= now_r;
          if (last_r == '0) begin
            count_r <= '0;
            sum_r   <= '0;
          end else begin
            count_r <= count_r + 1'b1;
            sum_r   <= sum_r + diff;
          end
        end else if (mode_r == hcio_pkg::MODE_SYNC) begin
          last_r <= '0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.mode       = mode_r;
  assign sts.measure_ok = measure_ok;
  assign sts.out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = rd_r;
  assign out_ch.tone_frequency = freq_r;
  assign out_ch.tone_valid     = tv_r;

endmodule

// ===== hdl/hcio_ctrl.sv =====
// Controller: sequences capture, execute, division and result load per request.
module hcio_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hcio_pkg::ctrl_sts_t  sts,
  output hcio_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                     state_r;
  logic [hcio_pkg::CNT_W-1:0] cnt_r;

  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.capture  = in_ready && in_valid;
  assign cmd.exec     = (state_r == ST_EXEC);
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.out_load = (state_r == ST_FIN) && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (sts.mode == hcio_pkg::MODE_SYNC && sts.measure_ok) begin
            state_r <= ST_DIV;
            cnt_r   <= hcio_pkg::CNT_W'(hcio_pkg::DIV_STEPS - 1);
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/home_computer_io_ports.sv =====
// Top level: I/O ports of an 8-bit home computer (timer, vsync, keyboard, speaker tone).
// Sequence: each request is captured, executed and loaded into the result register;
//   a sync tick with a measurement also runs the 57 steps of the bit-serial divider.
// Flow: one request at a time; the next is taken once the result is in the output
//   register, and the load waits while the output register is still full and not taken.
// Reset (rst_n, synchronous): clock rate 3579545, speaker state cleared, channels empty.
module home_computer_io_ports #(
  parameter int KEY_ROWS    = hcio_pkg::KEY_ROWS_DEF,
  parameter int KEY_COLUMNS = hcio_pkg::KEY_COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  hcio_in_if.sink                     in_ch,
  hcio_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [hcio_pkg::RATE_W-1:0] cfg_wr_data
);

  hcio_pkg::ctrl_cmd_t cmd;
  hcio_pkg::ctrl_sts_t sts;

  hcio_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hcio_datapath #(
    .KEY_ROWS    (KEY_ROWS),
    .KEY_COLUMNS (KEY_COLUMNS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_ch.mode),
    .in_port_address (in_ch.port_address),
    .in_write_data   (in_ch.write_data),
    .in_cycle_count  (in_ch.cycle_count),
    .in_timer_ms     (in_ch.timer_ms),
    .in_vsync_active (in_ch.vsync_active),
    .in_key_matrix   (in_ch.key_matrix),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_ch          (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the home computer I/O port block: self-checking random and directed requests.
`timescale 1ns / 100ps

module tb;
  import hcio_pkg::*;

  typedef struct {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [WORD_W-1:0] cycle;
    logic [WORD_W-1:0] timer;
    logic              vsync;
    logic [KEY_W-1:0]  keys;
  } port_req_t;

  typedef struct {
    logic [7:0]        read_data;
    logic [FREQ_W-1:0] freq;
    logic              tone_valid;
  } port_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [RATE_W-1:0] cfg_wr_data;

  hcio_in_if  in_ch ();
  hcio_out_if out_ch ();

  home_computer_io_ports dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [RATE_W-1:0] clock_rate = RATE_RESET;
  logic              spk_level  = 1'b0;
  logic [WORD_W-1:0] last_flip  = '0;
  logic [WORD_W-1:0] flip_count = '0;
  logic [WORD_W-1:0] flip_sum   = '0;

  port_req_t    pending_reqs[$];
  port_result_t expected_results[$];
  port_req_t    drive_req;
  port_req_t    taken_req;
  port_result_t want;

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 70;
  logic        req_taken = 1'b0;
  logic        tone_lvl = 1'b0;

  function automatic port_result_t port_response(port_req_t r);
    port_result_t res;
    logic [7:0]        port;
    logic [WORD_W-1:0] tdiv;
    logic [7:0]        rows;
    logic [KEY_W-1:0]  colmask;
    logic [WORD_W-1:0] diff;
    logic [63:0]       num;
    logic [63:0]       quo;
    res.read_data  = RD_IDLE;
    res.freq       = '0;
    res.tone_valid = 1'b0;
    port = r.addr[7:0];
    case (r.mode)
      MODE_READ: begin
        if (port < 8'd4) begin
          tdiv = r.timer / 32'd10;
          res.read_data = 8'(tdiv >> (port * 8));
        end else if (port == PORT_VSYNC) begin
          res.read_data = {7'd0, r.vsync};
        end else if (port == PORT_KEYS) begin
          rows = '0;
          colmask = (KEY_W'(1) << KEY_COLUMNS_DEF) - 1;
          for (int i = 0; i < KEY_ROWS_DEF; i++) begin
            if (!r.addr[ROW_SEL_LSB + i]) begin
              rows = rows | 8'((r.keys >> (i * KEY_COLUMNS_DEF)) & colmask);
            end
          end
          res.read_data = ~rows;
        end
      end
      MODE_WRITE: begin
        if (port == PORT_SPEAKER && r.wdata[0] != spk_level) begin
          spk_level = r.wdata[0];
          if (last_flip == '0) begin
            flip_count = '0;
            flip_sum   = '0;
          end else begin
            diff = (r.cycle >= last_flip) ? r.cycle - last_flip : last_flip - r.cycle;
            flip_count = flip_count + 1;
            flip_sum   = flip_sum + diff;
          end
          last_flip = r.cycle;
        end
      end
      MODE_SYNC: begin
        if (last_flip != '0 && flip_count != '0 && flip_sum != '0) begin
          num = 64'(clock_rate >> 1) * 64'(flip_count);
          quo = num / 64'(flip_sum);
          res.freq = (quo > 64'(FREQ_MAX)) ? FREQ_MAX : quo[FREQ_W-1:0];
        end
        last_flip = '0;
        res.tone_valid = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] a, input logic [7:0] d,
                          input logic [WORD_W-1:0] c, input logic [WORD_W-1:0] t,
                          input logic v, input logic [KEY_W-1:0] k);
    port_req_t r;
    r.mode  = m;
    r.addr  = a;
    r.wdata = d;
    r.cycle = c;
    r.timer = t;
    r.vsync = v;
    r.keys  = k;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic noise_req(input mode_t m);
    logic [7:0] port;
    case ($urandom_range(0, 5))
      0: port = 8'($urandom_range(0, 3));
      1: port = PORT_SPEAKER;
      2: port = PORT_VSYNC;
      3: port = PORT_KEYS;
      default: port = 8'($urandom);
    endcase
    send_req(m, {8'($urandom), port}, 8'($urandom), $urandom, $urandom, 1'($urandom),
             KEY_W'({$urandom, $urandom}));
  endtask

  // speaker flips at a roughly steady interval, then usually a sync tick
  task automatic tone_burst();
    int unsigned n;
    int unsigned ival;
    int unsigned kind;
    logic [WORD_W-1:0] t;
    n = $urandom_range(1, 12);
    kind = $urandom_range(0, 7);
    t = ($urandom_range(0, 3) == 0) ? WORD_W'($urandom_range(0, 3)) : $urandom;
    if (kind == 0) ival = $urandom_range(0, 3);
    else if (kind == 1) ival = $urandom;
    else ival = $urandom_range(20, 20000);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) noise_req(MODE_READ);
      if ($urandom_range(0, 5) != 0) tone_lvl = ~tone_lvl;
      send_req(MODE_WRITE, {8'($urandom), PORT_SPEAKER}, {7'($urandom), tone_lvl}, t,
               $urandom, 1'($urandom), KEY_W'({$urandom, $urandom}));
      if ($urandom_range(0, 9) == 0) t = t - $urandom_range(0, ival);
      else t = t + ival + $urandom_range(0, ival / 8);
    end
    if ($urandom_range(0, 5) != 0) noise_req(MODE_SYNC);
  endtask

  task automatic wait_idle(input int unsigned tail);
    @(negedge clk);
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic set_rate(input logic [RATE_W-1:0] v);
    wait_idle(8);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    clock_rate = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_chunk(input int unsigned count);
    int unsigned stop_at;
    stop_at = n_queued + count;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 9) < 6) tone_burst();
      else noise_req(mode_t'($urandom_range(0, 3)));
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!in_ch.valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_req = pending_reqs.pop_front();
          in_ch.mode         <= drive_req.mode;
          in_ch.port_address <= drive_req.addr;
          in_ch.write_data   <= drive_req.wdata;
          in_ch.cycle_count  <= drive_req.cycle;
          in_ch.timer_ms     <= drive_req.timer;
          in_ch.vsync_active <= drive_req.vsync;
          in_ch.key_matrix   <= drive_req.keys;
          in_ch.valid        <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_error("result with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_error($sformatf("read_data got %h want %h", out_ch.read_data,
                                   want.read_data));
          if (out_ch.tone_frequency !== want.freq)
            report_error($sformatf("tone_frequency got %0d want %0d", out_ch.tone_frequency,
                                   want.freq));
          if (out_ch.tone_valid !== want.tone_valid)
            report_error($sformatf("tone_valid got %b want %b", out_ch.tone_valid,
                                   want.tone_valid));
        end
      end
      req_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        taken_req.mode  = mode_t'(in_ch.mode);
        taken_req.addr  = in_ch.port_address;
        taken_req.wdata = in_ch.write_data;
        taken_req.cycle = in_ch.cycle_count;
        taken_req.timer = in_ch.timer_ms;
        taken_req.vsync = in_ch.vsync_active;
        taken_req.keys  = in_ch.key_matrix;
        expected_results.push_back(port_response(taken_req));
        n_accepted++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_READ;
    in_ch.port_address = '0;
    in_ch.write_data   = '0;
    in_ch.cycle_count  = '0;
    in_ch.timer_ms     = '0;
    in_ch.vsync_active = 1'b0;
    in_ch.key_matrix   = '0;
    out_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset clock rate
    send_req(MODE_READ, 16'h0000, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b0, '0);
    send_req(MODE_READ, 16'hFF01, 8'hFF, 32'd0, 32'hFFFF_FFFF, 1'b1, '1);
    send_req(MODE_READ, 16'h5A02, 8'h00, 32'd0, 32'h1234_5678, 1'b0, '0);
    send_req(MODE_READ, 16'h0003, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b0, '0);
    send_req(MODE_READ, 16'h00FD, 8'h00, 32'd0, 32'd0, 1'b1, '0);
    send_req(MODE_READ, 16'hABFD, 8'h00, 32'd0, 32'd0, 1'b0, '1);
    send_req(MODE_READ, 16'h00FF, 8'h00, 32'd0, 32'd0, 1'b0, '1);
    send_req(MODE_READ, 16'hFFFF, 8'h00, 32'd0, 32'd0, 1'b0, '1);
    send_req(MODE_READ, 16'hFEFF, 8'h00, 32'd0, 32'd0, 1'b0, 48'hA5C3_0F1E_7B29);
    send_req(MODE_READ, 16'h0004, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b1, '1);
    send_req(MODE_READ, 16'hFFFE, 8'h00, 32'd0, 32'hFFFF_FFFF, 1'b1, '1);
    send_req(MODE_SYNC, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b0, '0);
    // flip at cycle zero, then first real flip clears the measurement
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd0, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h00, 32'd1000, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'hFFFC, 8'hFE, 32'd2000, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FD, 8'h01, 32'd3000, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd1500, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'hFE, 32'd2100, 32'd0, 1'b0, '0);
    send_req(MODE_SYNC, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1);
    send_req(MODE_SYNC, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b0, '0);
    // zero interval sum
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd5000, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h00, 32'd5000, 32'd0, 1'b0, '0);
    send_req(MODE_SYNC, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b0, '0);
    send_req(MODE_NONE, 16'h00FF, 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '1);

    // saturation at the top clock rate, exact maximum, then above it
    set_rate(26'h3FF_FFFF);
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd200, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h00, 32'd201, 32'd0, 1'b0, '0);
    send_req(MODE_SYNC, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd100, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h00, 32'd101, 32'd0, 1'b0, '0);
    send_req(MODE_WRITE, 16'h00FC, 8'h01, 32'd101, 32'd0, 1'b0, '0);
    send_req(MODE_SYNC, 16'h0000, 8'h00, 32'd0, 32'd0, 1'b0, '0);
    tone_lvl = 1'b1;
    random_chunk(117);
    set_rate(26'd1);
    random_chunk(117);

    send_idle_pct = 70;
    recv_idle_pct = 16;
    set_rate(26'($urandom_range(2, 26'h3FF_FFFF)));
    random_chunk(117);
    set_rate(26'd2);
    random_chunk(117);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_rate(26'($urandom_range(2, 26'h3FF_FFFF)));
    random_chunk(117);
    set_rate(RATE_RESET);
    random_chunk(117);

    wait_idle(70);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (n_errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hcio_pkg.sv
hdl/hcio_if.sv
hdl/hcio_datapath.sv
hdl/hcio_ctrl.sv
hdl/home_computer_io_ports.sv
tb/tb.sv
